// File: rtl/core/lgd_pkg.sv
// ----------------------------------------------------------------------------
// lgd_pkg
// Shared types and constants of the gamma-coded LZ77 decompressor.
// ----------------------------------------------------------------------------
package lgd_pkg;

  localparam int CNT_W           = 17;     // byte counters and lengths
  localparam int ADDR_W          = 16;     // history address
  localparam int BYTE_W          = 8;
  localparam int ACC_W           = 16;     // suffix / offset accumulator
  localparam int NBITS_W         = 5;      // offset bit count, ones count
  localparam int HIST_DEPTH      = 65536;
  localparam int WINDOW_SIZE_DEF = 65536;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int LIT_BITS        = 8;
  localparam int ONES_LIMIT      = 16;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [0:0] REG_TOTAL_LENGTH = 1'b0;

  typedef enum logic [2:0] {
    PH_FLAG,
    PH_LIT,
    PH_ONES,
    PH_SUFFIX,
    PH_OFFSET,
    PH_COPY
  } phase_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_LIT,
    OP_COPY
  } op_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_WRONG_PHASE,
    ST_TRUNCATED,
    ST_LEN_TOO_LONG
  } status_t;

  // one decoded item on its way to the copy engine
  typedef struct packed {
    op_t                op;
    logic [BYTE_W-1:0]  lit_byte;
    logic [ADDR_W-1:0]  rd_addr;
    logic [ADDR_W-1:0]  wr_addr;
    logic               copy_pending;
    logic               done;
    status_t            status;
  } cmd_t;

endpackage

// File: rtl/core/lgd_ram.sv
// ----------------------------------------------------------------------------
// lgd_ram
// Generic single-clock RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module lgd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/lgd_front.sv
// ----------------------------------------------------------------------------
// lgd_front
// Bit-stream decoder: flag, literal, gamma length and offset parsing.
// Keeps all counters and turns each item into one command for the copy engine.
// ----------------------------------------------------------------------------
module lgd_front #(
  parameter int WINDOW_SIZE = lgd_pkg::WINDOW_SIZE_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      take,
  input  logic                      kind,
  input  logic                      code_bit,
  input  logic [lgd_pkg::CNT_W-1:0] total_length,
  output lgd_pkg::cmd_t             cmd
);

  localparam int CNT_W   = lgd_pkg::CNT_W;
  localparam int ADDR_W  = lgd_pkg::ADDR_W;
  localparam int ACC_W   = lgd_pkg::ACC_W;
  localparam int NBITS_W = lgd_pkg::NBITS_W;
  localparam logic [CNT_W-1:0] WIN = CNT_W'(WINDOW_SIZE);

  lgd_pkg::phase_t     phase, phase_next;
  logic [NBITS_W-1:0]  ones_count, ones_count_next;
  logic [NBITS_W-1:0]  bit_count, bit_count_next;
  logic [ACC_W-1:0]    shift_accum, shift_accum_next;
  logic [CNT_W-1:0]    match_remaining, match_remaining_next;
  logic [ADDR_W-1:0]   copy_address, copy_address_next;
  logic [CNT_W-1:0]    produced_count, produced_count_next;
  logic [NBITS_W-1:0]  offset_bits, offset_bits_next;

  logic                done_now;
  logic [CNT_W-1:0]    produced_inc;
  logic [CNT_W-1:0]    match_dec;
  logic [NBITS_W-1:0]  bc_inc, bc_dec, ones_inc;
  logic [ACC_W-1:0]    acc_shift;
  logic [7:0]          lit_shift;
  logic [ADDR_W-1:0]   win_start;
  logic                pow2;
  logic                start_off, start_cp;
  logic [ACC_W-1:0]    cp_offset;
  lgd_pkg::op_t        op;
  lgd_pkg::status_t    st;

  assign done_now     = produced_count >= total_length;
  assign produced_inc = produced_count + 1'b1;
  assign match_dec    = match_remaining - 1'b1;
  assign bc_inc       = bit_count + 1'b1;
  assign bc_dec       = bit_count - 1'b1;
  assign ones_inc     = ones_count + 1'b1;
  assign acc_shift    = {shift_accum[ACC_W-2:0], code_bit};
  assign lit_shift    = {shift_accum[6:0], code_bit};
  assign win_start    = (produced_count >= WIN) ? ADDR_W'(produced_count - WIN) : '0;
  assign pow2         = (produced_count != '0) &&
                        ((produced_count & (produced_count - 1'b1)) == '0);

  always_comb begin
    phase_next           = phase;
    ones_count_next      = ones_count;
    bit_count_next       = bit_count;
    shift_accum_next     = shift_accum;
    match_remaining_next = match_remaining;
    copy_address_next    = copy_address;
    produced_count_next  = produced_count;
    op                   = lgd_pkg::OP_NONE;
    st                   = lgd_pkg::ST_OK;
    start_off            = 1'b0;
    start_cp             = 1'b0;
    cp_offset            = '0;

    if (kind) begin
      if (phase != lgd_pkg::PH_COPY) begin
        st = lgd_pkg::ST_WRONG_PHASE;
      end else if (done_now) begin
        st                   = lgd_pkg::ST_TRUNCATED;
        match_remaining_next = '0;
        phase_next           = lgd_pkg::PH_FLAG;
      end else begin
        op                   = lgd_pkg::OP_COPY;
        produced_count_next  = produced_inc;
        copy_address_next    = copy_address + 1'b1;
        match_remaining_next = match_dec;
        if (match_dec == '0) begin
          phase_next = lgd_pkg::PH_FLAG;
        end else if (produced_inc >= total_length) begin
          st                   = lgd_pkg::ST_TRUNCATED;
          match_remaining_next = '0;
          phase_next           = lgd_pkg::PH_FLAG;
        end
      end
    end else begin
      unique case (phase)
        lgd_pkg::PH_FLAG: begin
          if (done_now) begin
            st = lgd_pkg::ST_WRONG_PHASE;
          end else if (!code_bit) begin
            phase_next       = lgd_pkg::PH_LIT;
            bit_count_next   = '0;
            shift_accum_next = '0;
          end else begin
            phase_next      = lgd_pkg::PH_ONES;
            ones_count_next = '0;
          end
        end
        lgd_pkg::PH_LIT: begin
          shift_accum_next = ACC_W'(lit_shift);
          bit_count_next   = bc_inc;
          if (bc_inc >= NBITS_W'(lgd_pkg::LIT_BITS)) begin
            bit_count_next = '0;
            phase_next     = lgd_pkg::PH_FLAG;
            if (done_now) begin
              st = lgd_pkg::ST_TRUNCATED;
            end else begin
              op                  = lgd_pkg::OP_LIT;
              produced_count_next = produced_inc;
            end
          end
        end
        lgd_pkg::PH_ONES: begin
          if (code_bit) begin
            ones_count_next = ones_inc;
            if (ones_inc >= NBITS_W'(lgd_pkg::ONES_LIMIT)) begin
              st              = lgd_pkg::ST_LEN_TOO_LONG;
              ones_count_next = '0;
              phase_next      = lgd_pkg::PH_FLAG;
            end
          end else if (ones_count == '0) begin
            match_remaining_next = CNT_W'(2);
            start_off            = 1'b1;
          end else begin
            bit_count_next   = ones_count;
            shift_accum_next = '0;
            phase_next       = lgd_pkg::PH_SUFFIX;
          end
        end
        lgd_pkg::PH_SUFFIX: begin
          shift_accum_next = acc_shift;
          bit_count_next   = bc_dec;
          if (bc_dec == '0) begin
            match_remaining_next = (CNT_W'(1) << ones_count[3:0]) +
                                   CNT_W'(acc_shift) + 1'b1;
            start_off = 1'b1;
          end
        end
        lgd_pkg::PH_OFFSET: begin
          shift_accum_next = acc_shift;
          bit_count_next   = bc_dec;
          if (bc_dec == '0) begin
            start_cp  = 1'b1;
            cp_offset = acc_shift;
          end
        end
        default: begin
          st = lgd_pkg::ST_WRONG_PHASE;
        end
      endcase
    end

    // window of zero or one byte: no offset bits, copy starts at once; else the offset bits follow
    if (start_off) begin
      shift_accum_next = '0;
      if (offset_bits == '0) begin
        start_cp = 1'b1;
      end else begin
        bit_count_next = offset_bits;
        phase_next     = lgd_pkg::PH_OFFSET;
      end
    end
    if (start_cp) begin
      copy_address_next = win_start + cp_offset;
      phase_next        = lgd_pkg::PH_COPY;
    end
  end

  // ceil(log2(fill)) tracked as the byte count grows
  always_comb begin
    offset_bits_next = offset_bits;
    if (op != lgd_pkg::OP_NONE) begin
      if (produced_inc == '0) begin
        offset_bits_next = '0;
      end else if (produced_count < WIN && pow2) begin
        offset_bits_next = offset_bits + 1'b1;
      end
    end
  end

  always_comb begin
    cmd.op           = op;
    cmd.lit_byte     = lit_shift;
    cmd.rd_addr      = copy_address;
    cmd.wr_addr      = produced_count[ADDR_W-1:0];
    cmd.copy_pending = (phase_next == lgd_pkg::PH_COPY) && (match_remaining_next != '0);
    cmd.done         = produced_count_next >= total_length;
    cmd.status       = st;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= lgd_pkg::PH_FLAG;
      ones_count      <= '0;
      bit_count       <= '0;
      shift_accum     <= '0;
      match_remaining <= '0;
      copy_address    <= '0;
      produced_count  <= '0;
      offset_bits     <= '0;
    end else if (take) begin
      phase           <= phase_next;
      ones_count      <= ones_count_next;
      bit_count       <= bit_count_next;
      shift_accum     <= shift_accum_next;
      match_remaining <= match_remaining_next;
      copy_address    <= copy_address_next;
      produced_count  <= produced_count_next;
      offset_bits     <= offset_bits_next;
    end
  end

endmodule

// File: rtl/core/lgd_queue.sv
// ----------------------------------------------------------------------------
// lgd_queue
// Short command queue between the decoder and the copy engine.
// ----------------------------------------------------------------------------
module lgd_queue #(
  parameter int QUEUE_DEPTH = lgd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  lgd_pkg::cmd_t push_cmd,
  input  logic          pop,
  output lgd_pkg::cmd_t head,
  output logic          not_empty,
  output logic          full
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  lgd_pkg::cmd_t  entry [QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr, rd_ptr;
  logic [CW-1:0]  count;

  assign head      = entry[rd_ptr];
  assign not_empty = count != '0;
  assign full      = count == CW'(QUEUE_DEPTH);

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/core/lgd_back.sv
// ----------------------------------------------------------------------------
// lgd_back
// Copy engine: reads the history window, writes every produced byte back,
// and holds the result in an output register.
// ----------------------------------------------------------------------------
module lgd_back (
  input  logic                       clk,
  input  logic                       rst,
  input  lgd_pkg::cmd_t              head,
  input  logic                       head_valid,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       byte_valid,
  output logic [lgd_pkg::BYTE_W-1:0] out_byte,
  output logic                       copy_pending,
  output logic                       done_res,
  output logic [1:0]                 status
);

  localparam int BYTE_W = lgd_pkg::BYTE_W;

  lgd_pkg::cmd_t      s1;
  logic               s1_valid;
  logic               s1_fwd;
  logic [BYTE_W-1:0]  s1_fwd_byte;
  logic [BYTE_W-1:0]  rdata;
  logic [BYTE_W-1:0]  s1_byte;
  logic               s1_writes;
  logic               s1_adv;

  assign s1_writes = s1.op != lgd_pkg::OP_NONE;
  assign s1_adv    = s1_valid && (!out_valid || !out_stall);
  assign pop       = head_valid && (!s1_valid || s1_adv);

  // the byte written in the same cycle as the read is bypassed
  always_comb begin
    if (s1.op == lgd_pkg::OP_COPY) begin
      s1_byte = s1_fwd ? s1_fwd_byte : rdata;
    end else begin
      s1_byte = s1.lit_byte;
    end
  end

  lgd_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (lgd_pkg::HIST_DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (s1_adv && s1_writes),
    .waddr (s1.wr_addr),
    .wdata (s1_byte),
    .re    (pop),
    .raddr (head.rd_addr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (pop) begin
      s1          <= head;
      s1_fwd      <= s1_valid && s1_writes && (s1.wr_addr == head.rd_addr);
      s1_fwd_byte <= s1_byte;
    end
    if (s1_adv) begin
      byte_valid   <= s1_writes;
      out_byte     <= s1_writes ? s1_byte : '0;
      copy_pending <= s1.copy_pending;
      done_res     <= s1.done;
      status       <= s1.status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (!out_valid || !out_stall) begin
        out_valid <= s1_valid;
      end
    end
  end

endmodule

// File: rtl/core/lz77_gamma_decompressor_top.sv
// ----------------------------------------------------------------------------
// lz77_gamma_decompressor_top
// LZ77 decompressor with gamma-coded match lengths, one stream bit or one
// match byte per input item.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): kind 0 brings one compressed bit in
// code_bit, kind 1 pulls the next byte of an open match. Every input transfer
// gives exactly one result on the output channel (out_valid / out_stall),
// in order.
// Throughput is one item per cycle while the command queue has room: each item
// needs one history read and one history write, and the window RAM has a port
// for each. A result passes from the command queue through the copy stage to
// the output register.
// The decoder runs ahead of the copy engine through a four-entry command
// queue; in_stall rises only once that queue is full, so a stalled receiver
// backs up the output register, the copy stage and then the queue.
// total_length is to be written over the APB port only while the block is idle,
// which the block does not enforce; a read returns it. Reset clears the decoder
// state, byte count and queue, not the window RAM; it needs no time after reset.
// ----------------------------------------------------------------------------
module lz77_gamma_decompressor_top #(
  parameter int WINDOW_SIZE = lgd_pkg::WINDOW_SIZE_DEF,
  parameter int QUEUE_DEPTH = lgd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // apb
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lgd_pkg::PADDR_W-1:0] paddr,
  input  logic [lgd_pkg::PDATA_W-1:0] pwdata,
  output logic [lgd_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  // input items
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        kind,
  input  logic                        code_bit,
  // results
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        byte_valid,
  output logic [lgd_pkg::BYTE_W-1:0]  out_byte,
  output logic                        copy_pending,
  output logic                        done_res,
  output logic [1:0]                  status
);

  localparam int CNT_W = lgd_pkg::CNT_W;

  logic [CNT_W-1:0] total_length;
  logic             reg_hit;
  logic             take;
  logic             q_full, q_not_empty, q_pop;
  lgd_pkg::cmd_t    front_cmd, q_head;

  assign pready  = 1'b1;
  assign reg_hit = paddr[lgd_pkg::PADDR_W-1:2] == lgd_pkg::REG_TOTAL_LENGTH;
  assign prdata  = reg_hit ? lgd_pkg::PDATA_W'(total_length) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      total_length <= '0;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      total_length <= pwdata[CNT_W-1:0];
    end
  end

  assign in_stall = q_full;
  assign take     = in_valid && !q_full;

  lgd_front #(
    .WINDOW_SIZE (WINDOW_SIZE)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .kind         (kind),
    .code_bit     (code_bit),
    .total_length (total_length),
    .cmd          (front_cmd)
  );

  lgd_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (take),
    .push_cmd  (front_cmd),
    .pop       (q_pop),
    .head      (q_head),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  lgd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (q_head),
    .head_valid   (q_not_empty),
    .pop          (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .byte_valid   (byte_valid),
    .out_byte     (out_byte),
    .copy_pending (copy_pending),
    .done_res     (done_res),
    .status       (status)
  );

endmodule

// File: tb/lgd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgd_checker
// Scoreboard for the gamma-coded LZ77 decompressor. Follows total_length on
// the APB port, decodes every input transfer with its own window and decoder
// state, and compares each result transfer, in order, field by field.
// ----------------------------------------------------------------------------
module lgd_checker
  import lgd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  input  logic [PDATA_W-1:0] prdata,
  input  logic               pready,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               kind,
  input  logic               code_bit,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               byte_valid,
  input  logic [BYTE_W-1:0]  out_byte,
  input  logic               copy_pending,
  input  logic               done_res,
  input  logic [1:0]         status,
  output int                 fail_count,
  output int                 pending
);

  localparam logic [PADDR_W-1:0] LEN_ADDR = PADDR_W'(4 * REG_TOTAL_LENGTH);

  typedef struct packed {
    logic              byte_ok;
    logic [BYTE_W-1:0] data;
    logic              copying;
    logic              finished;
    status_t           st;
  } dec_res_t;

  // decoder copy, window deliberately left unset after reset like the ram
  logic [BYTE_W-1:0] window [0:HIST_DEPTH-1];
  phase_t            ph;
  int                ones_run;
  int                bits_left;
  logic [ACC_W-1:0]  acc;
  logic [CNT_W-1:0]  copy_left;
  logic [ADDR_W-1:0] copy_ptr;
  logic [CNT_W-1:0]  byte_count;
  logic [CNT_W-1:0]  len_limit;
  dec_res_t          byte_results [$];

  initial begin
    fail_count = 0;
  end

  task automatic report(input string what, input int got, input int want);
    fail_count++;
    $display("%0t: %s differs: got %0h, wanted %0h", $time, what, got, want);
  endtask

  function automatic int window_fill();
    return (byte_count < WINDOW_SIZE_DEF) ? int'(byte_count) : WINDOW_SIZE_DEF;
  endfunction

  task automatic open_copy(input logic [ACC_W-1:0] off);
    copy_ptr = ADDR_W'(int'(byte_count) - window_fill() + int'(off));
    ph       = PH_COPY;
  endtask

  task automatic open_offset();
    int nb;
    nb  = $clog2(window_fill());
    acc = '0;
    if (nb == 0) begin
      open_copy('0);
    end else begin
      bits_left = nb;
      ph        = PH_OFFSET;
    end
  endtask

  task automatic decode(input logic k, input logic b, output dec_res_t r);
    r.byte_ok = 1'b0;
    r.data    = '0;
    r.st      = ST_OK;
    if (k) begin
      if (ph != PH_COPY) begin
        r.st = ST_WRONG_PHASE;
      end else if (byte_count >= len_limit) begin
        r.st      = ST_TRUNCATED;
        copy_left = '0;
        ph        = PH_FLAG;
      end else begin
        r.data    = window[copy_ptr];
        r.byte_ok = 1'b1;
        window[byte_count[ADDR_W-1:0]] = r.data;
        byte_count++;
        copy_ptr++;
        copy_left--;
        if (copy_left == 0) begin
          ph = PH_FLAG;
        end else if (byte_count >= len_limit) begin
          // match cut short by the length limit
          r.st      = ST_TRUNCATED;
          copy_left = '0;
          ph        = PH_FLAG;
        end
      end
    end else begin
      case (ph)
        PH_FLAG: begin
          if (byte_count >= len_limit) begin
            r.st = ST_WRONG_PHASE;
          end else if (!b) begin
            ph        = PH_LIT;
            bits_left = 0;
            acc       = '0;
          end else begin
            ph       = PH_ONES;
            ones_run = 0;
          end
        end
        PH_LIT: begin
          acc = {8'h00, acc[6:0], b};
          bits_left++;
          if (bits_left >= LIT_BITS) begin
            bits_left = 0;
            ph        = PH_FLAG;
            if (byte_count >= len_limit) begin
              r.st = ST_TRUNCATED;
            end else begin
              r.data    = acc[BYTE_W-1:0];
              r.byte_ok = 1'b1;
              window[byte_count[ADDR_W-1:0]] = r.data;
              byte_count++;
            end
          end
        end
        PH_ONES: begin
          if (b) begin
            ones_run++;
            if (ones_run >= ONES_LIMIT) begin
              r.st     = ST_LEN_TOO_LONG;
              ones_run = 0;
              ph       = PH_FLAG;
            end
          end else if (ones_run == 0) begin
            copy_left = CNT_W'(2);
            open_offset();
          end else begin
            bits_left = ones_run;
            acc       = '0;
            ph        = PH_SUFFIX;
          end
        end
        PH_SUFFIX: begin
          acc = {acc[ACC_W-2:0], b};
          bits_left--;
          if (bits_left == 0) begin
            copy_left = CNT_W'((1 << (ones_run % 16)) + int'(acc) + 1);
            open_offset();
          end
        end
        PH_OFFSET: begin
          acc = {acc[ACC_W-2:0], b};
          bits_left--;
          if (bits_left == 0) begin
            open_copy(acc);
          end
        end
        default: begin
          r.st = ST_WRONG_PHASE;
        end
      endcase
    end
    r.copying  = (ph == PH_COPY) && (copy_left != 0);
    r.finished = (byte_count >= len_limit);
  endtask

  always @(posedge clk) begin
    dec_res_t want;
    dec_res_t fresh;
    if (rst) begin
      ph         = PH_FLAG;
      ones_run   = 0;
      bits_left  = 0;
      acc        = '0;
      copy_left  = '0;
      copy_ptr   = '0;
      byte_count = '0;
      len_limit  = '0;
      byte_results.delete();
    end else begin
      if (psel && penable && pready && paddr == LEN_ADDR) begin
        if (pwrite) begin
          len_limit = pwdata[CNT_W-1:0];
        end else if (prdata !== PDATA_W'(len_limit)) begin
          report("total_length readback", prdata, len_limit);
        end
      end
      if (out_valid && !out_stall) begin
        if (byte_results.size() == 0) begin
          report("result transfer with none outstanding", out_byte, 0);
        end else begin
          want = byte_results.pop_front();
          if (byte_valid !== want.byte_ok) report("byte_valid", byte_valid, want.byte_ok);
          if (out_byte !== want.data) report("out_byte", out_byte, want.data);
          if (copy_pending !== want.copying) report("copy_pending", copy_pending, want.copying);
          if (done_res !== want.finished) report("done_res", done_res, want.finished);
          if (status !== want.st) report("status", status, want.st);
        end
      end
      if (in_valid && !in_stall) begin
        decode(kind, code_bit, fresh);
        byte_results.push_back(fresh);
      end
    end
    pending <= byte_results.size();
  end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the gamma-coded LZ77 decompressor: directed corner cases, then
// random well-formed literal and match sequences mixed with stray and broken
// codes, under random stalls on both channels and several length settings.
// ----------------------------------------------------------------------------
module tb;
  import lgd_pkg::*;

  localparam int ITEM_TARGET = 900;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [PADDR_W-1:0] LEN_ADDR = PADDR_W'(4 * REG_TOTAL_LENGTH);

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               in_valid;
  logic               in_stall;
  logic               kind;
  logic               code_bit;
  logic               out_valid;
  logic               out_stall;
  logic               byte_valid;
  logic [BYTE_W-1:0]  out_byte;
  logic               copy_pending;
  logic               done_res;
  logic [1:0]         status;

  int fails;
  int pending;
  int made       = 0;   // bytes the block should have produced so far
  int limit      = 0;
  int good_items = 0;
  int cycles     = 0;
  int hold_left  = 0;
  bit calm       = 1'b0;
  bit stray      = 1'b0;
  bit held       = 1'b0;

  lz77_gamma_decompressor_top uut (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .kind        (kind),
    .code_bit    (code_bit),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .byte_valid  (byte_valid),
    .out_byte    (out_byte),
    .copy_pending(copy_pending),
    .done_res    (done_res),
    .status      (status)
  );

  lgd_checker chk (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .kind        (kind),
    .code_bit    (code_bit),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .byte_valid  (byte_valid),
    .out_byte    (out_byte),
    .copy_pending(copy_pending),
    .done_res    (done_res),
    .status      (status),
    .fail_count  (fails),
    .pending     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result side: random stalls, plus a long hold-off when asked for
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (!calm && $urandom_range(99) < 38) begin
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_item(input logic k, input logic b);
    while (!calm && $urandom_range(99) < 38) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind     <= k;
    code_bit <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (!stray) good_items++;
  endtask

  // an item the block only ignores
  task automatic stray_item(input logic k, input logic b);
    stray = 1'b1;
    send_item(k, b);
    stray = 1'b0;
  endtask

  task automatic send_bits(input int unsigned value, input int n);
    for (int i = n - 1; i >= 0; i--) send_item(1'b0, value[i]);
  endtask

  task automatic send_literal(input logic [BYTE_W-1:0] v);
    send_item(1'b0, 1'b0);
    send_bits(v, LIT_BITS);
    if (made < limit) made++;
  endtask

  task automatic pull_bytes(input int n);
    for (int i = 0; i < n; i++) begin
      // a code bit in the middle of an open match is ignored
      if (i > 0 && $urandom_range(29) == 0) stray_item(1'b0, 1'($urandom_range(1)));
      send_item(1'b1, 1'($urandom_range(1)));
      if (made < limit) made++;
    end
  endtask

  task automatic copy_match(input int q, input int unsigned sfx, input int unsigned off);
    int fill;
    int len;
    fill = (made < WINDOW_SIZE_DEF) ? made : WINDOW_SIZE_DEF;
    send_item(1'b0, 1'b1);
    repeat (q) send_item(1'b0, 1'b1);
    send_item(1'b0, 1'b0);
    send_bits(sfx, q);
    send_bits(off, $clog2(fill));
    len = (1 << q) + sfx + 1;
    if (len > limit - made) len = limit - made;
    pull_bytes(len);
  endtask

  task automatic too_long_code();
    send_item(1'b0, 1'b1);
    repeat (ONES_LIMIT) send_item(1'b0, 1'b1);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_limit(input int v);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= LEN_ADDR;
    pwdata  <= PDATA_W'(v);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    // read back straight after the write
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    limit = v;
  endtask

  task automatic new_setting();
    int v;
    case ($urandom_range(3))
      0:       v = WINDOW_SIZE_DEF;
      3:       v = $urandom_range(WINDOW_SIZE_DEF - 1, made + 1);
      default: v = made + $urandom_range(40, 1);
    endcase
    set_limit(v);
  endtask

  initial begin
    int r;
    int q;
    rst      <= 1'b1;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    in_valid <= 1'b0;
    kind     <= 1'b0;
    code_bit <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // length 0 after reset: flag bit and pull are both ignored
    send_item(1'b0, 1'b1);
    send_item(1'b1, 1'b0);

    // match on an empty window reads no offset bits; close it without reading
    set_limit(5);
    send_item(1'b0, 1'b1);
    send_item(1'b0, 1'b0);
    send_item(1'b0, 1'b1);
    set_limit(0);
    send_item(1'b1, 1'b0);

    set_limit(1);
    send_literal(8'h00);
    set_limit(WINDOW_SIZE_DEF);
    send_literal(8'hFF);
    send_literal(8'hA5);
    send_literal(8'h5A);
    copy_match(0, 0, 3);
    copy_match(1, 1, 0);
    copy_match(2, 3, made - 1);
    too_long_code();

    // longest length code, cut short by the limit, then pull and flag once done
    set_limit(made + 3);
    copy_match(15, 16'h7FFF, made - 1);
    send_item(1'b1, 1'b1);
    send_item(1'b0, 1'b0);

    // literal that completes once the limit has been reached is dropped
    set_limit(WINDOW_SIZE_DEF);
    send_item(1'b0, 1'b0);
    send_bits(4'hC, 4);
    set_limit(made);
    send_bits(4'h3, 4);
    set_limit(WINDOW_SIZE_DEF);

    good_items = 0;
    while (good_items < ITEM_TARGET) begin
      calm = (good_items >= 400 && good_items < 550);
      if (!held && good_items >= 200) begin
        held      = 1'b1;
        hold_left = 150;
      end
      if (made >= limit || $urandom_range(59) == 0) new_setting();
      r = $urandom_range(99);
      if (r < 45) begin
        send_literal(BYTE_W'($urandom_range(255)));
      end else if (r < 88) begin
        q = ($urandom_range(11) == 0) ? $urandom_range(6, 4) : $urandom_range(3);
        copy_match(q, (q == 0) ? 0 : $urandom_range((1 << q) - 1),
                   $urandom_range(((made < WINDOW_SIZE_DEF) ? made : WINDOW_SIZE_DEF) - 1));
      end else if (r < 93) begin
        stray_item(1'b1, 1'($urandom_range(1)));
      end else if (r < 97) begin
        too_long_code();
      end else begin
        send_literal(($urandom_range(1) == 0) ? 8'h00 : 8'hFF);
      end
    end

    calm = 1'b0;
    drain();
    repeat (10) @(posedge clk);
    if (fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
